@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high
`define GRE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define GRE_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/gre_pkg.sv @@
// Types and constants of the Givens rotation engine
package gre_pkg;

  localparam int WORD_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int OPND_W    = 33;
  localparam int COEF_BITS = 30;
  localparam int DATA_WIDTH = 32;

  typedef logic [WIDE_W-1:0] wide_t;

  // Result of the shared compare-subtract unit
  typedef struct packed {
    logic  ge;
    wide_t diff;
  } sub_res_t;

  localparam logic signed [WORD_W-1:0] COS_ONE = 32'sh4000_0000;
  localparam wide_t U_ONE = 64'h1000_0000_0000_0000;

  // Clamp bounds of the signed data range
  localparam logic signed [WIDE_W-1:0] DATA_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] DATA_MIN = -DATA_MAX - 64'sd1;

endpackage

@@ rtl/givens_rotation_engine_top.sv @@
// Givens rotation engine: one compare-subtract unit and one multiplier under
// a sequencer. A compute transaction (req_type 0) turns (a,b) into a stored
// rotation and returns (c,s) in Q1.30 by way of the bit-serial ratio divide
// (31 steps), the reciprocal divide (61 steps) and the square root (31 steps),
// all on the one compare-subtract unit. With b equal to zero it skips them and
// stores the identity rotation. An apply transaction (req_type 1) rotates
// (x,y) with the stored rotation by four passes through the shared multiplier.
// One transaction is worked on at a time; a finished result sits in the output
// register, so the next transaction can be taken while it waits. Reset leaves
// the identity rotation stored.
module givens_rotation_engine_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic signed [gre_pkg::WORD_W-1:0] first_operand,
  input  logic signed [gre_pkg::WORD_W-1:0] second_operand,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [gre_pkg::WORD_W-1:0] first_result,
  output logic signed [gre_pkg::WORD_W-1:0] second_result,
  output logic                              saturated
);
  import gre_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_UADD = 4'd4;
  localparam logic [3:0] S_REC  = 4'd5;
  localparam logic [3:0] S_SQI  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_WMUL = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_AP0  = 4'd10;
  localparam logic [3:0] S_AP1  = 4'd11;
  localparam logic [3:0] S_AP2  = 4'd12;
  localparam logic [3:0] S_AP3  = 4'd13;
  localparam logic [3:0] S_AP4  = 4'd14;
  localparam logic [3:0] S_AP5  = 4'd15;

  localparam int QUO_W = 61;
  localparam int TM_W  = 31;

  logic [3:0]               state;
  logic                     done_pend;
  logic signed [WORD_W-1:0] a_reg, b_reg;
  logic                     b_big, same_sign;
  wide_t                    rem, dvs;
  logic [QUO_W-1:0]         quo;
  logic [5:0]               cnt;
  logic [TM_W-1:0]          tm;
  logic signed [WORD_W-1:0] cos_reg, sin_reg;
  logic signed [WIDE_W-1:0] acc1, acc2;
  logic signed [WORD_W-1:0] res1, res2;
  logic                     res_sat;

  wide_t                    sub_x, sub_y;
  sub_res_t                 sub_out;
  logic signed [OPND_W-1:0] mul_a, mul_b;
  logic signed [WIDE_W-1:0] mul_p;

  logic [OPND_W-1:0]        mag_a, mag_b;
  logic                     b_big_c;
  wide_t                    step_sel;
  logic [TM_W-1:0]          wm;
  logic signed [WORD_W-1:0] r_val, w_val;
  logic signed [WIDE_W-1:0] sh1, sh2, cl1, cl2;
  logic                     sat1, sat2;
  logic                     out_free;

  gre_sub u_sub (.x(sub_x), .y(sub_y), .res(sub_out));
  gre_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(mul_p));

  // The result hand-off waits in done_pend rather than a state of its own
  assign in_ready = (state == S_IDLE) && !done_pend;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    mag_a   = a_reg[WORD_W-1] ? (33'd0 - {a_reg[WORD_W-1], a_reg}) : {1'b0, a_reg};
    mag_b   = b_reg[WORD_W-1] ? (33'd0 - {b_reg[WORD_W-1], b_reg}) : {1'b0, b_reg};
    b_big_c = mag_b > mag_a;
  end

  // Operand select for the compare-subtract unit
  always_comb begin
    if (state == S_SQRT) begin
      sub_x = {rem[WIDE_W-3:0], dvs[QUO_W:QUO_W-1]};
      sub_y = {1'b0, quo, 2'b01};
    end else begin
      sub_x = rem;
      sub_y = dvs;
    end
    step_sel = sub_out.ge ? sub_out.diff : rem;
  end

  // Operand select for the multiplier
  always_comb begin
    unique case (state)
      S_SQ: begin
        mul_a = {2'b00, quo[TM_W-1:0]};
        mul_b = {2'b00, quo[TM_W-1:0]};
      end
      S_WMUL: begin
        mul_a = {2'b00, quo[TM_W-1:0]};
        mul_b = {2'b00, tm};
      end
      S_AP0: begin
        mul_a = {cos_reg[WORD_W-1], cos_reg};
        mul_b = {a_reg[WORD_W-1], a_reg};
      end
      S_AP1: begin
        mul_a = {sin_reg[WORD_W-1], sin_reg};
        mul_b = {b_reg[WORD_W-1], b_reg};
      end
      S_AP2: begin
        mul_a = {sin_reg[WORD_W-1], sin_reg};
        mul_b = {a_reg[WORD_W-1], a_reg};
      end
      S_AP3: begin
        mul_a = {cos_reg[WORD_W-1], cos_reg};
        mul_b = {b_reg[WORD_W-1], b_reg};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Final product r*t and the apply-path shift and clamp
  always_comb begin
    wm    = mul_p[COEF_BITS+TM_W-1:COEF_BITS];
    r_val = {1'b0, quo[TM_W-1:0]};
    w_val = (same_sign && (tm != '0)) ? (32'sd0 - {1'b0, wm}) : {1'b0, wm};
    sh1   = acc1 >>> COEF_BITS;
    sh2   = acc2 >>> COEF_BITS;
    sat1  = (sh1 > DATA_MAX) || (sh1 < DATA_MIN);
    sat2  = (sh2 > DATA_MAX) || (sh2 < DATA_MIN);
    cl1   = sat1 ? ((sh1 > DATA_MAX) ? DATA_MAX : DATA_MIN) : sh1;
    cl2   = sat2 ? ((sh2 > DATA_MAX) ? DATA_MAX : DATA_MIN) : sh2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_pend <= 1'b0;
      out_valid <= 1'b0;
      cos_reg   <= COS_ONE;
      sin_reg   <= '0;
    end else begin
      if (done_pend && out_free) begin
        done_pend     <= 1'b0;
        out_valid     <= 1'b1;
        first_result  <= res1;
        second_result <= res2;
        saturated     <= res_sat;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            a_reg <= first_operand;
            b_reg <= second_operand;
            state <= req_type ? S_AP0 : S_PREP;
          end
        end
        S_PREP: begin
          if (b_reg == '0) begin
            cos_reg   <= COS_ONE;
            sin_reg   <= '0;
            res1      <= COS_ONE;
            res2      <= '0;
            res_sat   <= 1'b0;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            b_big     <= b_big_c;
            same_sign <= (a_reg[WORD_W-1] == b_reg[WORD_W-1]);
            rem       <= {31'd0, (b_big_c ? mag_a : mag_b)};
            dvs       <= {31'd0, (b_big_c ? mag_b : mag_a)};
            quo       <= '0;
            cnt       <= 6'd30;
            state     <= S_DIV;
          end
        end
        S_DIV, S_REC: begin
          // restoring divide, one quotient bit per cycle
          quo <= {quo[QUO_W-2:0], sub_out.ge};
          rem <= {step_sel[WIDE_W-2:0], 1'b0};
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= (state == S_DIV) ? S_SQ : S_SQI;
          end
        end
        S_SQ: begin
          tm    <= quo[TM_W-1:0];
          state <= S_UADD;
        end
        S_UADD: begin
          dvs   <= U_ONE + wide_t'(mul_p);
          rem   <= U_ONE;
          quo   <= '0;
          cnt   <= 6'd60;
          state <= S_REC;
        end
        S_SQI: begin
          dvs   <= {3'b000, quo};
          rem   <= '0;
          quo   <= '0;
          cnt   <= 6'd30;
          state <= S_SQRT;
        end
        S_SQRT: begin
          // digit-by-digit root, two radicand bits per cycle
          rem <= sub_out.ge ? sub_out.diff : sub_x;
          quo <= {quo[QUO_W-2:0], sub_out.ge};
          dvs <= {dvs[WIDE_W-3:0], 2'b00};
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            state <= S_WMUL;
          end
        end
        S_WMUL: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (b_big) begin
            sin_reg <= r_val;
            cos_reg <= w_val;
            res1    <= w_val;
            res2    <= r_val;
          end else begin
            cos_reg <= r_val;
            sin_reg <= w_val;
            res1    <= r_val;
            res2    <= w_val;
          end
          res_sat   <= 1'b0;
          done_pend <= 1'b1;
          state     <= S_IDLE;
        end
        S_AP0: state <= S_AP1;
        S_AP1: begin
          acc1  <= mul_p;
          state <= S_AP2;
        end
        S_AP2: begin
          acc1  <= acc1 - mul_p;
          state <= S_AP3;
        end
        S_AP3: begin
          acc2  <= mul_p;
          state <= S_AP4;
        end
        S_AP4: begin
          acc2  <= acc2 + mul_p;
          state <= S_AP5;
        end
        S_AP5: begin
          res1      <= cl1[WORD_W-1:0];
          res2      <= cl2[WORD_W-1:0];
          res_sat   <= sat1 || sat2;
          done_pend <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/gre_sub.sv @@
// Shared compare-subtract unit for the divide and square-root steps
module gre_sub (
  input  gre_pkg::wide_t    x,
  input  gre_pkg::wide_t    y,
  output gre_pkg::sub_res_t res
);
  import gre_pkg::*;

  logic [WIDE_W:0] full;

  // borrow out of the top bit means x < y
  assign full     = {1'b0, x} - {1'b0, y};
  assign res.ge   = ~full[WIDE_W];
  assign res.diff = full[WIDE_W-1:0];

endmodule

@@ rtl/gre_mul.sv @@
// Shared signed multiplier with registered product
module gre_mul (
  input  logic                              clk,
  input  logic signed [gre_pkg::OPND_W-1:0] op_a,
  input  logic signed [gre_pkg::OPND_W-1:0] op_b,
  output logic signed [gre_pkg::WIDE_W-1:0] prod
);
  import gre_pkg::*;

  logic signed [2*OPND_W-1:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    prod <= signed'(full[WIDE_W-1:0]);
  end

endmodule

@@ rtl/gre_checker.sv @@
// Port-level checker for the Givens rotation engine, bound to the top level
`include "assert_macros.svh"

module gre_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              req_type,
  input logic signed [gre_pkg::WORD_W-1:0] first_operand,
  input logic signed [gre_pkg::WORD_W-1:0] second_operand,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [gre_pkg::WORD_W-1:0] first_result,
  input logic signed [gre_pkg::WORD_W-1:0] second_result,
  input logic                              saturated
);
  import gre_pkg::*;

  localparam logic [WORD_W-1:0] MAX_W = DATA_MAX[WORD_W-1:0];
  localparam logic [WORD_W-1:0] MIN_W = DATA_MIN[WORD_W-1:0];

  logic              sat_bound;
  logic              in_take, in_stall, out_stall;
  logic [2*WORD_W:0] in_word, out_word;

  assign sat_bound = (first_result == MAX_W) || (first_result == MIN_W) ||
                     (second_result == MAX_W) || (second_result == MIN_W);
  assign in_take   = in_valid && in_ready;
  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;
  assign in_word   = {req_type, first_operand, second_operand};
  assign out_word  = {first_result, second_result, saturated};

  `GRE_ASSERT_RST(a_reset_state, clk, rst |=> (!out_valid && in_ready), "bad state after reset")
  `GRE_ASSERT(a_busy_after_accept, clk, rst, in_take |=> !in_ready, "took back to back")
  `GRE_ASSERT(a_in_hold, clk, rst, in_stall |=> (in_valid && $stable(in_word)), "input moved")
  `GRE_ASSERT(a_out_hold, clk, rst, out_stall |=> (out_valid && $stable(out_word)), "result moved")
  `GRE_ASSERT(a_sat_clipped, clk, rst, (out_valid && saturated) |-> sat_bound, "flag, no clip")

endmodule

bind givens_rotation_engine_top gre_checker u_gre_checker (.*);
